[rtl/pcc_pkg.sv]
// ---------------------------------------------------------------------------
// pcc_pkg
// Shared codes, widths and controller/datapath interface types for the
// pileup column consensus block.
// ---------------------------------------------------------------------------
package pcc_pkg;

  localparam int unsigned CODE_W    = 3;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned OUT_CNT_W = 8;
  localparam int unsigned QSTEPS    = 7;
  localparam int unsigned NUM_OPS   = 4;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned STEP_W    = 3;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [CODE_W-1:0] BASE_NONE = 3'd0;
  localparam logic [CODE_W-1:0] BASE_A    = 3'd1;
  localparam logic [CODE_W-1:0] BASE_T    = 3'd2;
  localparam logic [CODE_W-1:0] BASE_G    = 3'd3;
  localparam logic [CODE_W-1:0] BASE_C    = 3'd4;
  localparam logic [CODE_W-1:0] BASE_DEL  = 3'd5;

  localparam logic [OP_W-1:0] OP_INS   = 2'd0;
  localparam logic [OP_W-1:0] OP_LCLIP = 2'd1;
  localparam logic [OP_W-1:0] OP_RCLIP = 2'd2;
  localparam logic [OP_W-1:0] OP_BEST  = 2'd3;

  typedef struct packed {
    logic              take;
    logic              close;
    logic              select;
    logic              div_step;
    logic              div_last;
    logic [OP_W-1:0]   op;
    logic [STEP_W-1:0] step;
    logic              out_load;
  } pcc_cmd_t;

  typedef struct packed {
    logic out_full;
  } pcc_status_t;

endpackage

[rtl/pcc_ctrl.sv]
// ---------------------------------------------------------------------------
// pcc_ctrl
// Sequencer: accumulates cells, then walks the consensus pick, the four
// percentage divisions and the result load.
// ---------------------------------------------------------------------------
module pcc_ctrl import pcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_last_i,
  input  logic        out_ready_i,
  input  pcc_status_t status_i,
  output logic        in_ready_o,
  output pcc_cmd_t    cmd_o
);

  localparam logic [1:0] S_ACCUM  = 2'd0;
  localparam logic [1:0] S_SELECT = 2'd1;
  localparam logic [1:0] S_DIVIDE = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              fire;
  logic              step_end;

  assign in_ready_o = (state_q == S_ACCUM);
  assign fire       = in_valid_i && in_ready_o;
  assign step_end   = (step_q == STEP_W'(QSTEPS - 1));

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    step_d        = step_q;
    cmd_o         = '0;
    cmd_o.op      = op_q;
    cmd_o.step    = step_q;
    unique case (state_q)
      S_ACCUM: begin
        cmd_o.take  = fire;
        cmd_o.close = fire && in_last_i;
        if (fire && in_last_i) begin
          state_d = S_SELECT;
        end
      end
      S_SELECT: begin
        cmd_o.select = 1'b1;
        op_d         = OP_INS;
        step_d       = '0;
        state_d      = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_last = step_end;
        if (step_end) begin
          step_d = '0;
          if (op_q == OP_BEST) begin
            state_d = S_EMIT;
          end else begin
            op_d = op_q + 1'b1;
          end
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_EMIT: begin
        if (!status_i.out_full || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_ACCUM;
        end
      end
      default: begin
        state_d = S_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACCUM;
      op_q    <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      step_q  <= step_d;
    end
  end

endmodule

[rtl/pcc_datapath.sv]
// ---------------------------------------------------------------------------
// pcc_datapath
// Column tallies, column snapshot, first-maximum pick, shared restoring
// divider for the percentages and the result register.
// ---------------------------------------------------------------------------
module pcc_datapath import pcc_pkg::*; #(
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pcc_cmd_t              cmd_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output pcc_status_t           status_o
);

  localparam int unsigned CW  = COUNT_BITS;
  localparam int unsigned RW  = COUNT_BITS + PCT_W;
  localparam int unsigned EW  = (COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [RW-1:0] times100(input logic [CW-1:0] v);
    logic [RW-1:0] x;
    x = RW'(v);
    return (x << 6) + (x << 5) + (x << 2);
  endfunction

  function automatic logic [OUT_CNT_W-1:0] sat8(input logic [CW-1:0] v);
    logic [EW-1:0] x;
    x = EW'(v);
    return (x > EW'(255)) ? 8'hFF : x[OUT_CNT_W-1:0];
  endfunction

  logic [CODE_W-1:0] code;
  logic              lclip, rclip, ins;

  logic [CW-1:0] a_q, t_q, g_q, c_q, del_q, ins_q, lc_q, rc_q, reads_q, carry_q;
  logic [CW-1:0] a_u, t_u, g_u, c_u, del_u, ins_u, lc_u, rc_u, reads_u, carry_u;

  logic [CW-1:0] sa_q, st_q, sg_q, sc_q, sdel_q, sins_q, slc_q, src_q, sreads_q;

  logic [CODE_W-1:0] best_base_q, pick_base;
  logic [CW-1:0]     best_cnt_q, pick_cnt;
  logic [CW-1:0]     counts [5];

  logic [RW-1:0]    rem_q, shifted, next_num;
  logic [PCT_W-1:0] quo_q, quo_new;
  logic [STEP_W-1:0] shamt;
  logic             ge;
  logic [PCT_W-1:0] pct_q [NUM_OPS];

  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  assign code  = in_data_i[2:0];
  assign lclip = in_data_i[3];
  assign rclip = in_data_i[4];
  assign ins   = in_data_i[5];

  always_comb begin
    a_u = a_q; t_u = t_q; g_u = g_q; c_u = c_q; del_u = del_q;
    ins_u = ins_q; lc_u = lc_q; rc_u = rc_q; reads_u = reads_q; carry_u = carry_q;
    if (cmd_i.take && (code != BASE_NONE)) begin
      case (code)
        BASE_A:   a_u   = sat_inc(a_q);
        BASE_T:   t_u   = sat_inc(t_q);
        BASE_G:   g_u   = sat_inc(g_q);
        BASE_C:   c_u   = sat_inc(c_q);
        BASE_DEL: del_u = sat_inc(del_q);
        default: ;
      endcase
      if (rclip) begin
        carry_u = sat_inc(carry_q);
      end else if (lclip) begin
        lc_u = sat_inc(lc_q);
      end
      if (ins) begin
        ins_u = sat_inc(ins_q);
      end
      reads_u = sat_inc(reads_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0; t_q <= '0; g_q <= '0; c_q <= '0; del_q <= '0;
      ins_q <= '0; lc_q <= '0; rc_q <= '0; reads_q <= '0; carry_q <= '0;
    end else if (cmd_i.close) begin
      a_q <= '0; t_q <= '0; g_q <= '0; c_q <= '0; del_q <= '0;
      ins_q <= '0; lc_q <= '0;
      rc_q <= carry_u; reads_q <= carry_u; carry_q <= '0;
    end else begin
      a_q <= a_u; t_q <= t_u; g_q <= g_u; c_q <= c_u; del_q <= del_u;
      ins_q <= ins_u; lc_q <= lc_u; rc_q <= rc_u; reads_q <= reads_u;
      carry_q <= carry_u;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.close) begin
      sa_q <= a_u; st_q <= t_u; sg_q <= g_u; sc_q <= c_u; sdel_q <= del_u;
      sins_q <= ins_u; slc_q <= lc_u; src_q <= rc_u; sreads_q <= reads_u;
    end
  end

  assign counts[0] = sa_q;
  assign counts[1] = st_q;
  assign counts[2] = sg_q;
  assign counts[3] = sc_q;
  assign counts[4] = sdel_q;

  always_comb begin
    pick_base = BASE_NONE;
    pick_cnt  = '0;
    for (int i = 0; i < 5; i++) begin
      if (counts[i] > pick_cnt) begin
        pick_cnt  = counts[i];
        pick_base = CODE_W'(i + 1);
      end
    end
  end

  assign shamt   = STEP_W'(QSTEPS - 1) - cmd_i.step;
  assign shifted = RW'(sreads_q) << shamt;
  assign ge      = (rem_q >= shifted);
  assign quo_new = {quo_q[PCT_W-2:0], ge};

  always_comb begin
    case (cmd_i.op)
      OP_INS:   next_num = times100(slc_q);
      OP_LCLIP: next_num = times100(src_q);
      default:  next_num = times100(best_cnt_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.select) begin
      best_base_q <= pick_base;
      best_cnt_q  <= pick_cnt;
      rem_q       <= times100(sins_q);
    end else if (cmd_i.div_step) begin
      quo_q <= quo_new;
      if (cmd_i.div_last) begin
        pct_q[cmd_i.op] <= quo_new;
        rem_q           <= next_num;
      end else begin
        rem_q <= ge ? (rem_q - shifted) : rem_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (sreads_q == '0) begin
        out_data_q <= '0;
      end else begin
        out_data_q <= {1'b0, sat8(sreads_q), pct_q[OP_RCLIP], pct_q[OP_LCLIP],
                       pct_q[OP_INS], pct_q[OP_BEST], sat8(best_cnt_q), best_base_q};
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;
  assign status_o.out_full = out_valid_q;

endmodule

[rtl/pileup_column_consensus.sv]
// ---------------------------------------------------------------------------
// pileup_column_consensus
// Majority base call with insertion and clip percentages per pileup column.
// ---------------------------------------------------------------------------
// Cells are taken one per cycle while a column is open. The beat with tlast
// closes the column; tready then stays low through the first-maximum pick,
// four percentages through one shared restoring divider and the load of the
// result register, longer if the previous result has not yet been taken. A
// right-clipped cell counts as a read of its own column and as a read and a
// right clip of the following column, and all tallies saturate at
// 2**COUNT_BITS - 1.
module pileup_column_consensus import pcc_pkg::*; #(
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // base_code[2:0], lclip[3], rclip[4], has_insertion[5], zero[7:6]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic                  s_axis_tlast_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // best_base[2:0], best_count[10:3], best_percent[17:11],
  // insert_percent[24:18], lclip_percent[31:25],
  // rclip_percent[38:32], read_total[46:39], zero[47]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  pcc_cmd_t    cmd;
  pcc_status_t status;

  pcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_last_i   (s_axis_tlast_i),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .in_ready_o  (s_axis_tready_o),
    .cmd_o       (cmd)
  );

  pcc_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (s_axis_tdata_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .status_o    (status)
  );

`ifndef SYNTHESIS
  a_close_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("Input was accepted right after a column closed.");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[46:39] == 8'd0) |-> (m_axis_tdata_o[38:0] == 39'd0))
    else $error("An empty column reported nonzero fields.");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[17:11] <= 7'd100) && (m_axis_tdata_o[24:18] <= 7'd100)
      && (m_axis_tdata_o[31:25] <= 7'd100) && (m_axis_tdata_o[38:32] <= 7'd100))
    else $error("A percentage exceeds 100.");

  a_best_le_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[10:3] <= m_axis_tdata_o[46:39]))
    else $error("Best base count exceeds the read count.");
`endif

endmodule

[sim/tb_pileup_column_consensus.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_pileup_column_consensus
// Self-checking bench for the pileup column consensus block. Cells are
// streamed in as directed and random columns. A scoreboard tallies each
// accepted cell and predicts the call of every closed column. Each result
// beat is then checked field by field against the oldest predicted call.
// Idling phases, random stalls and one long receiver hold-off vary the
// timing on both sides.
// ---------------------------------------------------------------------------
module tb_pileup_column_consensus;
  import pcc_pkg::*;

  localparam int COUNT_BITS     = 8;
  localparam int TALLY_MAX      = (1 << COUNT_BITS) - 1;
  localparam int RANDOM_CELLS   = 160;
  localparam int LONG_COLUMN    = 270;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;

  localparam logic [CODE_W-1:0] CELL_INVALID    = 3'd6;
  localparam logic [CODE_W-1:0] CELL_INVALID_HI = 3'd7;
  localparam logic [CODE_W-1:0] BASE_ORDER [5] = '{BASE_A, BASE_T, BASE_G, BASE_C, BASE_DEL};

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              lclip;
    logic              rclip;
    logic              ins;
    logic              last;
  } cell_t;

  typedef struct packed {
    logic [CODE_W-1:0]    best_base;
    logic [OUT_CNT_W-1:0] best_count;
    logic [PCT_W-1:0]     best_pct;
    logic [PCT_W-1:0]     ins_pct;
    logic [PCT_W-1:0]     lclip_pct;
    logic [PCT_W-1:0]     rclip_pct;
    logic [OUT_CNT_W-1:0] reads;
  } call_t;

  localparam int DIRECTED_CELLS = 21;
  localparam cell_t DIRECTED [DIRECTED_CELLS] = '{
    '{BASE_NONE,       1'b1, 1'b1, 1'b1, 1'b1},
    '{BASE_A,          1'b1, 1'b0, 1'b0, 1'b0},
    '{BASE_T,          1'b0, 1'b0, 1'b1, 1'b0},
    '{BASE_G,          1'b0, 1'b0, 1'b0, 1'b0},
    '{BASE_C,          1'b1, 1'b1, 1'b0, 1'b0},
    '{BASE_DEL,        1'b0, 1'b0, 1'b0, 1'b1},
    '{CELL_INVALID,    1'b1, 1'b0, 1'b1, 1'b0},
    '{CELL_INVALID_HI, 1'b0, 1'b0, 1'b0, 1'b0},
    '{BASE_NONE,       1'b0, 1'b0, 1'b0, 1'b1},
    '{BASE_DEL,        1'b0, 1'b0, 1'b0, 1'b0},
    '{BASE_DEL,        1'b0, 1'b0, 1'b0, 1'b0},
    '{BASE_C,          1'b0, 1'b0, 1'b1, 1'b0},
    '{BASE_DEL,        1'b0, 1'b0, 1'b0, 1'b1},
    '{BASE_C,          1'b0, 1'b0, 1'b0, 1'b0},
    '{BASE_G,          1'b0, 1'b0, 1'b0, 1'b0},
    '{BASE_G,          1'b0, 1'b0, 1'b0, 1'b0},
    '{BASE_C,          1'b0, 1'b0, 1'b0, 1'b1},
    '{BASE_NONE,       1'b0, 1'b0, 1'b0, 1'b1},
    '{BASE_T,          1'b0, 1'b1, 1'b0, 1'b1},
    '{BASE_NONE,       1'b0, 1'b0, 1'b0, 1'b1},
    '{BASE_A,          1'b1, 1'b0, 1'b1, 1'b1}
  };

  class column_call_book;
    int    base_tally [5];
    int    ins_tally;
    int    lclip_tally;
    int    rclip_tally;
    int    read_tally;
    int    carry_rclip;
    call_t pending_calls [$];
    int    failures;

    function int bump(int v);
      return (v < TALLY_MAX) ? v + 1 : v;
    endfunction

    function logic [OUT_CNT_W-1:0] clip_count(int v);
      return (v > 255) ? 8'd255 : v[OUT_CNT_W-1:0];
    endfunction

    function logic [PCT_W-1:0] share_pct(int num, int den);
      int p;
      if (den == 0) return '0;
      p = num * 100 / den;
      return (p > 127) ? 7'd127 : p[PCT_W-1:0];
    endfunction

    function void note_cell(cell_t c);
      call_t call;
      int    best_cnt;
      if (c.code != BASE_NONE) begin
        case (c.code)
          BASE_A:   base_tally[0] = bump(base_tally[0]);
          BASE_T:   base_tally[1] = bump(base_tally[1]);
          BASE_G:   base_tally[2] = bump(base_tally[2]);
          BASE_C:   base_tally[3] = bump(base_tally[3]);
          BASE_DEL: base_tally[4] = bump(base_tally[4]);
          default: ;
        endcase
        if (c.rclip) carry_rclip = bump(carry_rclip);
        else if (c.lclip) lclip_tally = bump(lclip_tally);
        if (c.ins) ins_tally = bump(ins_tally);
        read_tally = bump(read_tally);
      end
      if (!c.last) return;
      call = '0;
      best_cnt = 0;
      if (read_tally != 0) begin
        for (int i = 0; i < 5; i++) begin
          if (base_tally[i] > best_cnt) begin
            best_cnt = base_tally[i];
            call.best_base = BASE_ORDER[i];
          end
        end
        call.best_count = clip_count(best_cnt);
        call.best_pct   = share_pct(best_cnt, read_tally);
        call.ins_pct    = share_pct(ins_tally, read_tally);
        call.lclip_pct  = share_pct(lclip_tally, read_tally);
        call.rclip_pct  = share_pct(rclip_tally, read_tally);
        call.reads      = clip_count(read_tally);
      end
      pending_calls = {pending_calls, call};
      base_tally  = '{default: 0};
      ins_tally   = 0;
      lclip_tally = 0;
      rclip_tally = carry_rclip;
      read_tally  = carry_rclip;
      carry_rclip = 0;
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        failures++;
      end
    endfunction

    function void check_call(logic [OUT_DATA_W-1:0] beat);
      call_t want;
      if (pending_calls.size() == 0) begin
        $error("result beat %h arrived with no column closed", beat);
        failures++;
        return;
      end
      want = pending_calls.pop_front();
      compare("best_base",      32'(want.best_base),  32'(beat[2:0]));
      compare("best_count",     32'(want.best_count), 32'(beat[10:3]));
      compare("best_percent",   32'(want.best_pct),   32'(beat[17:11]));
      compare("insert_percent", 32'(want.ins_pct),    32'(beat[24:18]));
      compare("lclip_percent",  32'(want.lclip_pct),  32'(beat[31:25]));
      compare("rclip_percent",  32'(want.rclip_pct),  32'(beat[38:32]));
      compare("read_total",     32'(want.reads),      32'(beat[46:39]));
      compare("pad",            32'd0,                32'(beat[47]));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic                  s_axis_tlast_i = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  column_call_book book = new;
  int   cells_sent = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_off = 1'b0;
  int   quiet_cycles = 0;

  pileup_column_consensus #(
    .COUNT_BITS(COUNT_BITS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_cell(cell_t c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, c.ins, c.rclip, c.lclip, c.code};
    s_axis_tlast_i  <= c.last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    book.note_cell(c);
    cells_sent++;
  endtask

  task automatic send_column(int len, logic [CODE_W-1:0] favored, int favor_pct,
                             int lclip_pct, int rclip_pct, int ins_pct);
    cell_t c;
    for (int k = 0; k < len; k++) begin
      c.code  = ($urandom_range(0, 99) < favor_pct) ? favored
                                                    : CODE_W'($urandom_range(0, 7));
      c.lclip = $urandom_range(0, 99) < lclip_pct;
      c.rclip = $urandom_range(0, 99) < rclip_pct;
      c.ins   = $urandom_range(0, 99) < ins_pct;
      c.last  = (k == len - 1);
      send_cell(c);
    end
  endtask

  task automatic set_idling(int phase);
    case (phase)
      0: begin
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
      end
      1: begin
        send_idle_pct  <= 63;
        recv_stall_pct <= 0;
      end
      2: begin
        send_idle_pct  <= 0;
        recv_stall_pct <= 63;
      end
      default: begin
        send_idle_pct  <= 18;
        recv_stall_pct <= 18;
      end
    endcase
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) book.check_call(m_axis_tdata_o);
      m_axis_tready_i <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // The receiver holds off long enough for the block to fill up and stall
  // its input while cells keep coming.
  initial begin
    wait (cells_sent >= 60);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int rand_cells;
    int len;
    bit long_done;
    rand_cells = 0;
    long_done  = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int k = 0; k < DIRECTED_CELLS; k++) send_cell(DIRECTED[k]);
    while (rand_cells < RANDOM_CELLS) begin
      set_idling(rand_cells * 4 / RANDOM_CELLS);
      if (!long_done && rand_cells >= RANDOM_CELLS / 3) begin
        // Both long columns saturate the read tally; the first is mostly G cells
        // with left clips and insertions, the second mostly right-clipped cells.
        send_column(LONG_COLUMN, BASE_G, 90, 90, 0, 90);
        send_column(LONG_COLUMN, BASE_A, 60, 10, 95, 10);
        long_done = 1'b1;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 12);
        send_column(len, CODE_W'($urandom_range(1, 5)), 40, 25, 15, 20);
        rand_cells += len;
      end
    end
    s_axis_tvalid_i <= 1'b0;
    s_axis_tlast_i  <= 1'b0;
    while (book.pending_calls.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (book.failures == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
